// ===== rtl/tcrg_pkg.sv =====
`timescale 1ns / 1ps

package tcrg_pkg;

  // Default glyph store depth and the width of the load address field.
  localparam int ROM_ENTRIES_DEF = 4096;
  localparam int ROM_ADDR_W      = 12;

  // Depth of the job queue between the front and back ends.
  localparam int Q_DEPTH = 2;

  // Item opcodes.
  localparam logic [1:0] OP_CTRL   = 2'd0;
  localparam logic [1:0] OP_MODE   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_RENDER = 2'd3;

  // Line types.
  localparam logic [1:0] LT_DH_BOTTOM = 2'd0;
  localparam logic [1:0] LT_DW        = 2'd1;
  localparam logic [1:0] LT_DH_TOP    = 2'd2;
  localparam logic [1:0] LT_NORMAL    = 2'd3;

  // Control commands, low nibble with bit 3 set.
  localparam logic [3:0] CMD_BLINK_TOGGLE = 4'h8;
  localparam logic [3:0] CMD_CLEAR_IRQ    = 4'h9;
  localparam logic [3:0] CMD_REVERSE_ON   = 4'ha;
  localparam logic [3:0] CMD_REVERSE_OFF  = 4'hb;
  localparam logic [3:0] CMD_BASE_NORMAL  = 4'hc;
  localparam logic [3:0] CMD_BASE_SHORT   = 4'hd;
  localparam logic [3:0] CMD_BLINK_CLEAR  = 4'he;

  // Cell geometry.
  localparam logic [3:0] UNDERLINE_SCAN    = 4'd8;
  localparam logic [3:0] BOTTOM_ROW_OFFSET = 4'd5;
  localparam logic [3:0] LAST_GLYPH_ROW    = 4'd15;

  // Result widths and pixel counts.
  localparam int PIX_N = 20;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_NORMAL_WIDE   = 5'd9;
  localparam logic [CNT_W-1:0] CNT_NORMAL_NARROW = 5'd10;
  localparam logic [CNT_W-1:0] CNT_DOUBLE_WIDE   = 5'd18;
  localparam logic [CNT_W-1:0] CNT_DOUBLE_NARROW = 5'd20;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_ALLOW_TALL_ADDR = 3'd0;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic       is_render;
    logic       irq;
    logic       wide;
    logic       tall;
    logic       fifty;
    logic       interlace;
    logic       watchdog;
    logic [3:0] scroll;
    logic       scroll_full;
    logic [3:0] scan_row;
    logic [3:0] attr;
    logic       blank;
    logic [1:0] line_type;
    logic       scr_rev;
    logic       base_attr;
    logic       blink_ph;
    logic [7:0] row;
  } job_t;

  // One finished result.
  typedef struct packed {
    logic [2*PIX_N-1:0] levels;
    logic [CNT_W-1:0]   count;
    logic               rep;
    logic               irq;
    logic               wide;
    logic               tall;
    logic               fifty;
    logic               interlace;
    logic               watchdog;
    logic [3:0]         scroll;
    logic               scroll_full;
  } result_t;

endpackage

// ===== rtl/tcrg_front.sv =====
`timescale 1ns / 1ps

module tcrg_front import tcrg_pkg::*; #(
  parameter int ROM_ENTRIES = ROM_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        allow_tall,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  write_data,
  input  logic [11:0] rom_address,
  input  logic [7:0]  char_code,
  input  logic [3:0]  scan_row,
  input  logic [3:0]  attribute_bits,
  input  logic        blank_cell,
  input  logic [1:0]  line_type,
  input  logic        job_ready,
  output logic        job_valid,
  output job_t        job
);

  localparam int AW = $clog2(ROM_ENTRIES);

  // Command state.
  logic       scr_rev_r,   scr_rev_nxt;
  logic       base_attr_r, base_attr_nxt;
  logic       blink_ph_r,  blink_ph_nxt;
  logic       wide_r,      wide_nxt;
  logic       tall_r,      tall_nxt;
  logic       fifty_r,     fifty_nxt;
  logic       interlace_r, interlace_nxt;
  logic       watchdog_r,  watchdog_nxt;
  logic [3:0] scroll_r,    scroll_nxt;
  logic       sfull_r,     sfull_nxt;
  logic       irq;

  // Stage register holding the classified item and its glyph row.
  logic       valid_r, valid_nxt;
  job_t       job_r,   job_nxt;
  logic [7:0] rom_q_r;
  logic [7:0] glyph_rom_r [ROM_ENTRIES];

  logic                  acc;
  logic [3:0]            row_sel;
  logic [ROM_ADDR_W-1:0] rd_full;
  logic [ROM_ADDR_W:0]   rd_wrap, wr_wrap;
  logic [AW-1:0]         rd_idx, wr_idx;

  assign in_ready = !valid_r || job_ready;
  assign acc      = in_valid && in_ready;

  // Glyph row within the character for the line type.
  always_comb begin
    case (line_type)
      LT_DH_BOTTOM: row_sel = {1'b0, scan_row[3:1]} + BOTTOM_ROW_OFFSET;
      LT_DH_TOP:    row_sel = {1'b0, scan_row[3:1]};
      default:      row_sel = scan_row;
    endcase
    row_sel = (row_sel == 4'd0) ? LAST_GLYPH_ROW : row_sel - 4'd1;
  end

  // Both store addresses stay below twice the depth when the depth exceeds 2048, so one subtract wraps them.
  assign rd_full = {char_code, row_sel};
  assign rd_wrap = ({1'b0, rd_full} >= (ROM_ADDR_W+1)'(ROM_ENTRIES))
                 ? {1'b0, rd_full} - (ROM_ADDR_W+1)'(ROM_ENTRIES) : {1'b0, rd_full};
  assign wr_wrap = ({1'b0, rom_address} >= (ROM_ADDR_W+1)'(ROM_ENTRIES))
                 ? {1'b0, rom_address} - (ROM_ADDR_W+1)'(ROM_ENTRIES)
                 : {1'b0, rom_address};
  assign rd_idx  = rd_wrap[AW-1:0];
  assign wr_idx  = wr_wrap[AW-1:0];

  // Command decode and state update.
  always_comb begin
    scr_rev_nxt   = scr_rev_r;
    base_attr_nxt = base_attr_r;
    blink_ph_nxt  = blink_ph_r;
    wide_nxt      = wide_r;
    tall_nxt      = tall_r;
    fifty_nxt     = fifty_r;
    interlace_nxt = interlace_r;
    watchdog_nxt  = watchdog_r;
    scroll_nxt    = scroll_r;
    sfull_nxt     = sfull_r;
    irq           = 1'b0;
    if (acc && opcode == OP_CTRL) begin
      watchdog_nxt = |write_data;
      if (!write_data[3]) begin
        if (!write_data[2]) begin
          sfull_nxt  = 1'b0;
          scroll_nxt = {2'b00, write_data[1:0]};
        end else begin
          sfull_nxt  = 1'b1;
          scroll_nxt = {write_data[1:0], scroll_r[1:0]};
        end
      end else begin
        case (write_data[3:0])
          CMD_BLINK_TOGGLE: blink_ph_nxt = !blink_ph_r;
          CMD_CLEAR_IRQ:    irq = 1'b1;
          CMD_REVERSE_ON:   scr_rev_nxt = 1'b1;
          CMD_REVERSE_OFF:  scr_rev_nxt = 1'b0;
          CMD_BASE_NORMAL: begin
            blink_ph_nxt  = 1'b0;
            base_attr_nxt = 1'b0;
          end
          CMD_BASE_SHORT: begin
            blink_ph_nxt  = 1'b0;
            base_attr_nxt = 1'b1;
            if (allow_tall) tall_nxt = 1'b0;
          end
          CMD_BLINK_CLEAR:  blink_ph_nxt = 1'b0;
          default: begin
            blink_ph_nxt  = 1'b0;
            base_attr_nxt = 1'b1;
            if (allow_tall) tall_nxt = 1'b1;
          end
        endcase
      end
    end else if (acc && opcode == OP_MODE) begin
      if (!write_data[5]) begin
        wide_nxt      = write_data[4];
        interlace_nxt = 1'b1;
      end else begin
        fifty_nxt     = write_data[4];
        interlace_nxt = 1'b0;
      end
    end
  end

  // Classified item; status reflects the state after the item.
  always_comb begin
    job_nxt             = job_r;
    job_nxt.is_render   = (opcode == OP_RENDER);
    job_nxt.irq         = irq;
    job_nxt.wide        = wide_nxt;
    job_nxt.tall        = tall_nxt;
    job_nxt.fifty       = fifty_nxt;
    job_nxt.interlace   = interlace_nxt;
    job_nxt.watchdog    = watchdog_nxt;
    job_nxt.scroll      = scroll_nxt;
    job_nxt.scroll_full = sfull_nxt;
    job_nxt.scan_row    = scan_row;
    job_nxt.attr        = attribute_bits;
    job_nxt.blank       = blank_cell;
    job_nxt.line_type   = line_type;
    job_nxt.scr_rev     = scr_rev_r;
    job_nxt.base_attr   = base_attr_r;
    job_nxt.blink_ph    = blink_ph_r;
    job_nxt.row         = 8'h00;
    if (acc) begin
      valid_nxt = 1'b1;
    end else if (job_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_rev_r   <= 1'b0;
      base_attr_r <= 1'b0;
      blink_ph_r  <= 1'b0;
      wide_r      <= 1'b0;
      tall_r      <= 1'b0;
      fifty_r     <= 1'b0;
      interlace_r <= 1'b1;
      watchdog_r  <= 1'b0;
      scroll_r    <= 4'd0;
      sfull_r     <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      scr_rev_r   <= scr_rev_nxt;
      base_attr_r <= base_attr_nxt;
      blink_ph_r  <= blink_ph_nxt;
      wide_r      <= wide_nxt;
      tall_r      <= tall_nxt;
      fifty_r     <= fifty_nxt;
      interlace_r <= interlace_nxt;
      watchdog_r  <= watchdog_nxt;
      scroll_r    <= scroll_nxt;
      sfull_r     <= sfull_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      job_r <= job_nxt;
    end
  end

  // Glyph store: one write port for loads, one registered read port for renders.
  always_ff @(posedge clk) begin
    if (acc && opcode == OP_LOAD) begin
      glyph_rom_r[wr_idx] <= write_data;
    end
    if (acc) begin
      rom_q_r <= glyph_rom_r[rd_idx];
    end
  end

  // Hand the item and its glyph row to the queue.
  always_comb begin
    job     = job_r;
    job.row = rom_q_r;
  end

  assign job_valid = valid_r;

endmodule

// ===== rtl/tcrg_queue.sv =====
`timescale 1ns / 1ps

module tcrg_queue import tcrg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  job_t           ent_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r,    cnt_nxt;
  logic           push, pop;

  assign pop_valid  = (cnt_r != '0);
  assign pop        = pop_valid && pop_ready;
  assign push_ready = (cnt_r != QCW'(Q_DEPTH)) || pop;
  assign push       = push_valid && push_ready;
  assign pop_job    = ent_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/tcrg_back.sv =====
`timescale 1ns / 1ps

module tcrg_back import tcrg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic    valid_r, valid_nxt;
  result_t res_r,   res_nxt;
  logic    pop;

  logic       invert, dbl;
  logic [1:0] fg, bg, blank_lvl;
  logic [7:0] row;
  logic [1:0] lv [8];
  logic [CNT_W-1:0] count;

  assign pop       = job_valid && (!valid_r || res_ready);
  assign job_ready = !valid_r || res_ready;

  // Foreground and background levels from the cell and screen attributes.
  always_comb begin
    invert = job.attr[0] ^ job.scr_rev ^ job.base_attr;
    fg     = job.attr[1] ? 2'd2 : 2'd3;
    if (!job.attr[2] && job.blink_ph) begin
      fg = fg - 2'd1;
    end
    bg = 2'd0;
    if (invert) begin
      bg = fg - 2'd1;
      if (bg != 2'd0) begin
        fg = 2'd0;
      end else begin
        fg = fg + 2'd1;
      end
    end
    // Underline row replaces the glyph row.
    row = job.row;
    if (!job.attr[3] && job.scan_row == UNDERLINE_SCAN) begin
      if (!invert) begin
        row = 8'hff;
      end else begin
        row = 8'h00;
        bg  = 2'd0;
      end
    end
    blank_lvl = {1'b0, job.scr_rev ^ job.base_attr};
    for (int b = 0; b < 8; b++) begin
      lv[b] = job.blank ? blank_lvl : (row[3'(7 - b)] ? fg : bg);
    end
  end

  // Pixel expansion: doubled pixels on double-size lines, last pixel fills the gap.
  always_comb begin
    dbl = (job.line_type != LT_NORMAL);
    if (dbl) begin
      count = job.wide ? CNT_DOUBLE_WIDE : CNT_DOUBLE_NARROW;
    end else begin
      count = job.wide ? CNT_NORMAL_WIDE : CNT_NORMAL_NARROW;
    end
    res_nxt             = res_r;
    res_nxt.irq         = job.irq;
    res_nxt.wide        = job.wide;
    res_nxt.tall        = job.tall;
    res_nxt.fifty       = job.fifty;
    res_nxt.interlace   = job.interlace;
    res_nxt.watchdog    = job.watchdog;
    res_nxt.scroll      = job.scroll;
    res_nxt.scroll_full = job.scroll_full;
    res_nxt.count       = job.is_render ? count : '0;
    res_nxt.rep         = job.is_render && !job.line_type[0];
    for (int p = 0; p < PIX_N; p++) begin
      if (job.is_render && CNT_W'(p) < count) begin
        if (dbl) begin
          res_nxt.levels[2*p +: 2] = (p / 2 > 7) ? lv[7] : lv[3'(p / 2)];
        end else begin
          res_nxt.levels[2*p +: 2] = (p > 7) ? lv[7] : lv[3'(p)];
        end
      end else begin
        res_nxt.levels[2*p +: 2] = 2'd0;
      end
    end
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/text_character_row_generator_top.sv =====
`timescale 1ns / 1ps

// Text-mode character row generator. Every input beat carries an opcode in in_tuser:
// a control command, a mode command, a load of one glyph byte, or a request to
// render one scan row of one character; each beat yields exactly one output beat
// with the rendered pixel levels (zero for non-render beats) and the command state
// after that beat. The block takes one beat per clock when the output side keeps
// up; each beat passes in order the glyph store's registered read in the front end,
// the two-entry job queue between the front and back ends, and the output
// register. Glyph bytes must be loaded before they are rendered: the store has no
// reset and an unloaded entry renders arbitrary pixels. The tall-mode enable at
// configuration address 0 resets to 1 and should be written only while idle.
module text_character_row_generator_top import tcrg_pkg::*; #(
  parameter int ROM_ENTRIES = ROM_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // write_data[7:0], rom_address[19:8], char_code[27:20], scan_row[31:28],
  // attribute_bits[35:32], blank_cell[36], line_type[38:37], zero[39]
  input  logic [39:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_levels[39:0], pixel_count[44:40], repeat_below[45],
  // clear_frame_irq[46], wide_columns[47], tall_lines[48], fifty_hertz[49],
  // interlace_on[50], watchdog_on[51], scroll_offset[55:52],
  // scroll_ready[56], zero[63:57]
  output logic [63:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic    allow_tall_r, allow_tall_nxt;
  logic    cfg_wr;
  logic    fe_valid, fe_ready;
  job_t    fe_job;
  logic    q_valid, q_ready;
  job_t    q_job;
  result_t res;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_ALLOW_TALL_ADDR) ? {31'd0, allow_tall_r} : 32'd0;

  always_comb begin
    allow_tall_nxt = allow_tall_r;
    if (cfg_wr && cfg_paddr == REG_ALLOW_TALL_ADDR) begin
      allow_tall_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_tall_r <= 1'b1;
    end else begin
      allow_tall_r <= allow_tall_nxt;
    end
  end

  // Front end: command decode, state and glyph store.
  tcrg_front #(
    .ROM_ENTRIES(ROM_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .allow_tall    (allow_tall_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .opcode        (in_tuser),
    .write_data    (in_tdata[7:0]),
    .rom_address   (in_tdata[19:8]),
    .char_code     (in_tdata[27:20]),
    .scan_row      (in_tdata[31:28]),
    .attribute_bits(in_tdata[35:32]),
    .blank_cell    (in_tdata[36]),
    .line_type     (in_tdata[38:37]),
    .job_ready     (fe_ready),
    .job_valid     (fe_valid),
    .job           (fe_job)
  );

  // Job queue.
  tcrg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fe_valid),
    .push_ready(fe_ready),
    .push_job  (fe_job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_job   (q_job)
  );

  // Back end: pixel rendering and output register.
  tcrg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_valid),
    .job_ready(q_ready),
    .job      (q_job),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {7'd0, res.scroll_full, res.scroll, res.watchdog, res.interlace,
                      res.fifty, res.tall, res.wide, res.irq, res.rep, res.count,
                      res.levels};

  // A beat without pixels carries no levels and no repeat request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44:40] == 5'd0 |-> out_tdata[39:0] == 40'd0 && !out_tdata[45])
    else $error("non-render beat carries pixel data");

  // A render beat has one of the four legal pixel counts.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44:40] != 5'd0 |->
      out_tdata[44:40] == CNT_NORMAL_WIDE || out_tdata[44:40] == CNT_NORMAL_NARROW ||
      out_tdata[44:40] == CNT_DOUBLE_WIDE || out_tdata[44:40] == CNT_DOUBLE_NARROW)
    else $error("illegal pixel count");

  // The interrupt clear pulse only comes with a command beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46] |-> out_tdata[44:40] == 5'd0)
    else $error("interrupt clear on a render beat");

  // A configuration write lands in the tall-mode enable.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_wr && cfg_paddr == REG_ALLOW_TALL_ADDR |=> allow_tall_r == $past(cfg_pwdata[0]))
    else $error("configuration write lost");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tcrg_pkg::*;

  // Control byte values that the package does not name.
  localparam logic [3:0] CMD_BASE_TALL = 4'hf;
  localparam logic [3:0] SCROLL_LOW    = 4'h0;
  localparam logic [3:0] SCROLL_HIGH   = 4'h4;

  // Mode byte values: bit 5 picks the refresh half, bit 4 is the setting.
  localparam logic [7:0] MODE_COLS_80  = 8'h00;
  localparam logic [7:0] MODE_COLS_132 = 8'h10;
  localparam logic [7:0] MODE_60HZ     = 8'h20;
  localparam logic [7:0] MODE_50HZ     = 8'h30;

  localparam int PIPE_LAT     = 3;
  localparam int IDLE_PCT     = 38;
  localparam int ITEM_TARGET  = 1550;
  localparam int PHASE_LEN    = 310;
  localparam int STEADY_START = 960;
  localparam int STEADY_END   = 1220;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  // One result beat, laid out so that out_tdata[56:0] casts straight into it.
  typedef struct packed {
    logic       scroll_full;
    logic [3:0] scroll;
    logic       watchdog;
    logic       interlace;
    logic       fifty;
    logic       tall;
    logic       wide;
    logic       irq;
    logic       rep;
    logic [4:0] count;
    logic [39:0] levels;
  } row_beat_t;

  // Tracks the command state and glyph store, and predicts every result beat.
  class row_predictor;
    bit [7:0]  glyph [0:4095];
    bit        scr_rev, base_attr, blink_ph, wide, tall, fifty, interlace, watchdog;
    bit [3:0]  scroll;
    bit        scroll_full;
    bit        allow_tall;
    row_beat_t pending_rows[$];
    int        errors;

    function new();
      scr_rev = 0; base_attr = 0; blink_ph = 0; wide = 0; tall = 0; fifty = 0;
      interlace = 1; watchdog = 0; scroll = 0; scroll_full = 0; allow_tall = 1;
      errors = 0;
    endfunction

    // Glyph row fetched for a scan line; double height stretches half a cell.
    function logic [3:0] row_index(logic [3:0] sl, logic [1:0] lt);
      logic [3:0] j;
      if (lt == LT_DH_BOTTOM) j = 4'(sl[3:1]) + BOTTOM_ROW_OFFSET;
      else if (lt == LT_DH_TOP) j = 4'(sl[3:1]);
      else j = sl;
      return (j == 4'd0) ? LAST_GLYPH_ROW : j - 4'd1;
    endfunction

    function void note_beat(logic [1:0] op, logic [39:0] d);
      row_beat_t  r;
      logic [7:0] wd, row, code;
      logic [3:0] sl, attr;
      logic [1:0] lt;
      logic       invert, blank;
      int         fg, back, lvl, n, fill, b;
      r = '0;
      wd = d[7:0];
      case (op)
        OP_CTRL: begin
          watchdog = (wd != 8'h00);
          if (!wd[3]) begin
            // Smooth-scroll latch: low half clears the full flag, high half sets it.
            if (!wd[2]) begin
              scroll_full = 0;
              scroll = {2'b00, wd[1:0]};
            end else begin
              scroll = {wd[1:0], scroll[1:0]};
              scroll_full = 1;
            end
          end else begin
            case (wd[3:0])
              CMD_BLINK_TOGGLE: blink_ph = !blink_ph;
              CMD_CLEAR_IRQ: r.irq = 1'b1;
              CMD_REVERSE_ON: scr_rev = 1;
              CMD_REVERSE_OFF: scr_rev = 0;
              CMD_BASE_NORMAL: begin
                blink_ph = 0;
                base_attr = 0;
              end
              CMD_BASE_SHORT: begin
                blink_ph = 0;
                base_attr = 1;
                if (allow_tall) tall = 0;
              end
              CMD_BLINK_CLEAR: blink_ph = 0;
              default: begin
                blink_ph = 0;
                base_attr = 1;
                if (allow_tall) tall = 1;
              end
            endcase
          end
        end
        OP_MODE: begin
          if (!wd[5]) begin
            wide = wd[4];
            interlace = 1;
          end else begin
            fifty = wd[4];
            interlace = 0;
          end
        end
        OP_LOAD: glyph[d[19:8]] = wd;
        default: begin
          code = d[27:20]; sl = d[31:28]; attr = d[35:32]; blank = d[36]; lt = d[38:37];
          invert = attr[0] ^ scr_rev ^ base_attr;
          fg = attr[1] ? 2 : 3;
          back = 0;
          if (!attr[2] && blink_ph) fg--;
          if (invert) begin
            back = fg - 1;
            if (back != 0) fg = 0;
            else fg++;
          end
          row = glyph[{code, row_index(sl, lt)}];
          // Underline replaces the glyph row on its own scan line.
          if (!attr[3] && sl == UNDERLINE_SCAN) begin
            if (!invert) row = 8'hff;
            else begin
              row = 8'h00;
              back = 0;
            end
          end
          n = 0;
          lvl = 0;
          for (b = 0; b < 8; b++) begin
            lvl = blank ? int'(scr_rev ^ base_attr) : (row[7-b] ? fg : back);
            r.levels |= 40'(lvl) << (2 * n);
            n++;
            if (lt != LT_NORMAL) begin
              r.levels |= 40'(lvl) << (2 * n);
              n++;
            end
          end
          // The last pixel is stretched into the gap column(s).
          fill = (lt != LT_NORMAL) ? 2 : 1;
          if (!wide) fill = 2 * fill;
          for (b = 0; b < fill; b++) begin
            r.levels |= 40'(lvl) << (2 * n);
            n++;
          end
          r.count = 5'(n);
          r.rep = !lt[0];
        end
      endcase
      r.wide = wide; r.tall = tall; r.fifty = fifty; r.interlace = interlace;
      r.watchdog = watchdog; r.scroll = scroll; r.scroll_full = scroll_full;
      pending_rows.push_back(r);
    endfunction

    function void check_beat(logic [63:0] t);
      row_beat_t got, exp;
      got = row_beat_t'(t[56:0]);
      if (pending_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", t);
        return;
      end
      exp = pending_rows.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("row mismatch (exp/got): levels %h/%h count %0d/%0d rep %b/%b irq %b/%b",
                   exp.levels, got.levels, exp.count, got.count, exp.rep, got.rep,
                   exp.irq, got.irq);
          $display("  wide %b/%b tall %b/%b fifty %b/%b ilace %b/%b wdog %b/%b scroll %h/%h full %b/%b",
                   exp.wide, got.wide, exp.tall, got.tall, exp.fifty, got.fifty,
                   exp.interlace, got.interlace, exp.watchdog, got.watchdog,
                   exp.scroll, got.scroll, exp.scroll_full, got.scroll_full);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [63:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  row_predictor rows;
  bit           glyph_loaded [0:4095];
  logic [7:0]   hot_codes [0:7];
  int           beats_sent, cfg_writes, cycles;
  int           beat_mix [0:3];
  bit           steady, hold_req;

  text_character_row_generator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at each edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) rows.note_beat(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) rows.check_beat(out_tdata);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (steady) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [39:0] pack_beat(logic [7:0] wd, logic [11:0] addr,
                                            logic [7:0] code, logic [3:0] sl,
                                            logic [3:0] attr, logic blank, logic [1:0] lt);
    return {1'b0, lt, blank, attr, sl, code, addr, wd};
  endfunction

  task automatic drive_beat(input logic [1:0] op, input logic [39:0] d);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    beat_mix[op]++;
  endtask

  // Command beats carry random bytes in the fields they do not use.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] wd);
    drive_beat(op, pack_beat(wd, 12'($urandom), 8'($urandom), 4'($urandom),
                             4'($urandom), 1'($urandom), 2'($urandom)));
  endtask

  task automatic send_load(input logic [11:0] addr, input logic [7:0] wd);
    drive_beat(OP_LOAD, pack_beat(wd, addr, 8'($urandom), 4'($urandom), 4'($urandom),
                                  1'($urandom), 2'($urandom)));
    glyph_loaded[addr] = 1;
  endtask

  // A render of a glyph row never loaded is preceded by a load of that row.
  task automatic send_render(input logic [7:0] code, input logic [3:0] sl,
                             input logic [3:0] attr, input logic blank, input logic [1:0] lt);
    logic [11:0] addr;
    addr = {code, rows.row_index(sl, lt)};
    if (!glyph_loaded[addr]) send_load(addr, 8'($urandom));
    drive_beat(OP_RENDER, pack_beat(8'($urandom), 12'($urandom), code, sl, attr, blank, lt));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (rows.pending_rows.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Tall-mode enable: write, then read back, with the block idle.
  task automatic write_allow_tall(input logic v);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_ALLOW_TALL_ADDR;
    cfg_pwdata  <= {31'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rows.allow_tall = v;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {31'b0, v}) begin
      rows.errors++;
      if (rows.errors <= 10) $display("tall enable readback: exp %0d got %h", v, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int         phase, pick;
    bit         hold_done;
    logic [7:0] code;
    rows = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = OP_CTRL;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    steady = 0; hold_req = 0; hold_done = 0;
    hot_codes[0] = 8'h00; hot_codes[1] = 8'hff; hot_codes[2] = 8'h41; hot_codes[3] = 8'ha5;
    hot_codes[4] = 8'h5a;
    for (int k = 5; k < 8; k++) hot_codes[k] = 8'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every mode and control command, scroll halves, and the render cases.
    send_cmd(OP_MODE, MODE_COLS_132);
    send_cmd(OP_MODE, MODE_50HZ);
    send_cmd(OP_MODE, MODE_60HZ);
    send_cmd(OP_MODE, MODE_COLS_80);
    send_cmd(OP_CTRL, {4'h0, SCROLL_LOW | 4'h3});
    send_cmd(OP_CTRL, {4'h0, SCROLL_HIGH | 4'h3});
    send_render(8'h00, 4'd0, 4'hf, 1'b0, LT_NORMAL);
    send_cmd(OP_CTRL, {4'h0, CMD_BLINK_TOGGLE});
    send_render(8'hff, 4'hf, 4'h0, 1'b0, LT_DH_BOTTOM);
    send_cmd(OP_CTRL, {4'hf, CMD_CLEAR_IRQ});
    send_cmd(OP_CTRL, {4'h0, CMD_REVERSE_ON});
    send_render(8'h00, UNDERLINE_SCAN, 4'h6, 1'b0, LT_DH_TOP);
    send_cmd(OP_CTRL, {4'h0, CMD_REVERSE_OFF});
    send_render(8'hff, UNDERLINE_SCAN, 4'h1, 1'b0, LT_NORMAL);
    send_cmd(OP_CTRL, {4'h0, CMD_BASE_SHORT});
    send_render(8'hff, 4'd9, 4'h5, 1'b1, LT_DW);
    send_cmd(OP_CTRL, {4'h0, CMD_BASE_TALL});
    send_cmd(OP_CTRL, {4'h0, CMD_BLINK_CLEAR});
    send_cmd(OP_CTRL, {4'h0, CMD_BASE_NORMAL});
    send_cmd(OP_CTRL, 8'h00);
    write_allow_tall(1'b0);

    // Random traffic, half of it renders, mostly over the eight hot characters.
    phase = 1;
    while (beats_sent < ITEM_TARGET) begin
      if (beats_sent >= phase * PHASE_LEN) begin
        write_allow_tall(phase[0]);
        phase++;
      end
      if (!hold_done && beats_sent >= STEADY_START) begin
        steady = 1;
        hold_req = 1;
        hold_done = 1;
      end
      if (steady && beats_sent >= STEADY_END) steady = 0;
      pick = $urandom_range(99);
      if (pick < 50) begin
        code = ($urandom_range(9) < 6) ? hot_codes[$urandom_range(7)] : 8'($urandom);
        send_render(code,
                    ($urandom_range(4) != 0) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10)),
                    4'($urandom), ($urandom_range(7) == 0), 2'($urandom));
      end else if (pick < 70) begin
        if ($urandom_range(1) == 0) send_load({hot_codes[$urandom_range(7)], 4'($urandom)},
                                              8'($urandom));
        else send_load(12'($urandom_range(4095)), 8'($urandom));
      end else if (pick < 90) begin
        send_cmd(OP_CTRL, ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom));
      end else begin
        send_cmd(OP_MODE, 8'($urandom));
      end
    end

    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk);
    rows.errors += rows.pending_rows.size();
    $display("Sent %0d beats: %0d renders, %0d glyph loads, %0d control, %0d mode beats.",
             beats_sent, beat_mix[OP_RENDER], beat_mix[OP_LOAD], beat_mix[OP_CTRL],
             beat_mix[OP_MODE]);
    $display("Tall-mode enable written %0d times; %0d mismatches.", cfg_writes, rows.errors);
    if (rows.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
